>>> design/pkmeter_pkg.sv
// Package for the peak meter with decaying hold: item and result types, register
// indexes, reset values and fixed-point constants of the decay evaluation.
// Depends on nothing; imported by pkmeter_decay and the core.
`default_nettype none

package pkmeter_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LEVEL_W     = 24;
  localparam int CH_FIELD_W  = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [LEVEL_W-1:0] AGE_MAX  = 24'hFFFFFF;
  localparam logic [16:0]        Q16_ONE  = 17'h10000;
  localparam logic [21:0]        T_CLAMP  = 22'(41 << 16);

  localparam logic [31:0]        TICK_RESET  = 32'd89478;
  localparam logic [15:0]        GAIN_RESET  = 16'd13107;
  localparam logic [LEVEL_W-1:0] FLOOR_RESET = 24'd839;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_SECONDS     = 2'd0,
    REG_DECAY_GAIN       = 2'd1,
    REG_HOLD_FLOOR       = 2'd2,
    REG_CLEAR_EACH_BLOCK = 2'd3
  } pkmeter_reg_t;

  typedef struct packed {
    logic                          mode;
    logic [CH_FIELD_W-1:0]         channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;
  } pkmeter_item_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] out_channel;
    logic [LEVEL_W-1:0]    block_peak;
    logic [LEVEL_W-1:0]    hold_raw;
    logic [LEVEL_W-1:0]    hold_level;
  } pkmeter_result_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] held;
    logic [LEVEL_W-1:0] age;
  } pkmeter_dec_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] level;
  } pkmeter_dec_rsp_t;

endpackage

`default_nettype wire

>>> design/pkmeter_decay.sv
// Decayed hold evaluation: held * (1 - gain * t^3), floored, on one shared multiplier.
// Five multiply steps per request. Depends on pkmeter_pkg.
`default_nettype none

module pkmeter_decay (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [31:0]                          tick_seconds,
  input  logic [15:0]                          decay_gain,
  input  logic [pkmeter_pkg::LEVEL_W-1:0]      hold_floor,
  input  pkmeter_pkg::pkmeter_dec_req_t        req,
  output pkmeter_pkg::pkmeter_dec_rsp_t        rsp
);
  import pkmeter_pkg::*;

  typedef enum logic [2:0] {D_IDLE, D_P, D_T2, D_T3, D_TERM, D_DEC} dstate_t;

  dstate_t            state;
  logic [LEVEL_W-1:0] held;
  logic [LEVEL_W-1:0] age;
  logic [21:0]        t;
  logic [32:0]        w;
  logic               done;
  logic [LEVEL_W-1:0] level;

  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        prod;
  logic [48:0]        p_shift;
  logic [LEVEL_W-1:0] dec_val;

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      D_P: begin
        mul_a = 33'(age);
        mul_b = tick_seconds;
      end
      D_T2: begin
        mul_a = 33'(t);
        mul_b = 32'(t);
      end
      D_T3: begin
        mul_a = w;
        mul_b = 32'(t);
      end
      D_TERM: begin
        mul_a = w;
        mul_b = 32'(decay_gain);
      end
      D_DEC: begin
        mul_a = 33'(held);
        mul_b = 32'(Q16_ONE - w[16:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = 65'(mul_a) * 65'(mul_b);
  assign p_shift = prod[64:16];
  // a term of one or more wipes the hold out
  assign dec_val = (w >= 33'(Q16_ONE)) ? '0 : prod[39:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            held  <= req.held;
            age   <= req.age;
            state <= D_P;
          end
        end
        D_P: begin
          t     <= (p_shift > 49'(T_CLAMP)) ? T_CLAMP : p_shift[21:0];
          state <= D_T2;
        end
        D_T2: begin
          w     <= p_shift[32:0];
          state <= D_T3;
        end
        D_T3: begin
          w     <= p_shift[32:0];
          state <= D_TERM;
        end
        D_TERM: begin
          w     <= p_shift[32:0];
          state <= D_DEC;
        end
        D_DEC: begin
          level <= (dec_val < hold_floor) ? hold_floor : dec_val;
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.busy  = (state != D_IDLE);
  assign rsp.done  = done;
  assign rsp.level = level;

endmodule

`default_nettype wire

>>> design/block_peak_meter_with_decaying_hold_core.sv
// Peak meter with decaying hold: per-channel state in one synchronous memory,
// read-modify-write sequencer and the decay unit. Depends on pkmeter_pkg, pkmeter_decay.
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   smp       smp_valid/smp_ready    pkmeter_item_t: mode, channel, sample, end
//   res       res_valid/res_ready    pkmeter_result_t: channel, peak, raw, level
//   cfg       cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// A sample that does not close a block is a memory read, then a write back.
// A sample that closes a block runs the read, two decay evaluations (5 multiply steps each)
// on the single shared multiplier, and the result load, which waits until the output
// register is free.
// A clear item is a read and a write back; an item beyond CHANNELS is dropped.
// Reset clears one valid bit per channel at once, so no clearing pass is run.
// A result waiting in the output register stalls only a later block end, at its load.
`default_nettype none

module block_peak_meter_with_decaying_hold_core #(
  parameter int CHANNELS  = 8,
  parameter int MAX_BLOCK = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  smp_valid,
  output logic                                  smp_ready,
  input  pkmeter_pkg::pkmeter_item_t            smp,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output pkmeter_pkg::pkmeter_result_t          res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pkmeter_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pkmeter_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pkmeter_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  // one memory word per channel
  typedef struct packed {
    logic [LEVEL_W-1:0] bmax;
    logic [CNT_W-1:0]   cnt;
    logic [LEVEL_W-1:0] held;
    logic [LEVEL_W-1:0] age;
  } chan_word_t;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_DECAY_OLD, S_DECAY_NEW, S_EMIT} state_t;

  // configuration registers
  logic [31:0]        tick_seconds;
  logic [15:0]        decay_gain;
  logic [LEVEL_W-1:0] hold_floor;
  logic               clear_each_block;

  // channel memory and its valid bits
  chan_word_t         mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  chan_word_t         rd_data;
  logic               rd_vld;

  // sequencer registers
  state_t                state;
  logic                  cur_mode;
  logic                  cur_end;
  logic [CH_W-1:0]       cur_ch;
  logic [CH_FIELD_W-1:0] cur_out_ch;
  logic [LEVEL_W-1:0]    cur_mag;
  logic [LEVEL_W-1:0]    peak;
  logic [CNT_W-1:0]      cnt;
  logic [LEVEL_W-1:0]    held;
  logic [LEVEL_W-1:0]    age;
  logic [LEVEL_W-1:0]    level;

  // combinational
  logic                        smp_acc;
  logic                        ch_ok;
  logic [CH_W-1:0]             in_idx;
  logic [SAMPLE_BITS:0]        mag_full;
  logic [SAMPLE_BITS+24:0]     mag_scaled;
  logic [LEVEL_W-1:0]          in_mag;
  chan_word_t                  word;
  logic [LEVEL_W-1:0]          new_max;
  logic [CNT_W-1:0]            new_cnt;
  logic [LEVEL_W:0]            age_sum;
  logic [LEVEL_W-1:0]          age_grown;
  logic                        take_peak;
  logic                        closing;
  logic                        mem_we;
  chan_word_t                  mem_wdata;
  logic                        res_load;
  pkmeter_dec_req_t            dec_req;
  pkmeter_dec_rsp_t            dec_rsp;

  // ---------------------------------------------------------------------------
  // Configuration: always ready; writes must arrive only while the block is idle, not enforced here.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_seconds     <= TICK_RESET;
      decay_gain       <= GAIN_RESET;
      hold_floor       <= FLOOR_RESET;
      clear_each_block <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TICK_SECONDS:     tick_seconds     <= cfg_data;
        REG_DECAY_GAIN:       decay_gain       <= cfg_data[15:0];
        REG_HOLD_FLOOR:       hold_floor       <= cfg_data[LEVEL_W-1:0];
        REG_CLEAR_EACH_BLOCK: clear_each_block <= cfg_data[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: take an item only with the sequencer idle. The previous write
  // back lands on the edge that returns to idle, so the read at accept always
  // sees it and no forwarding path is needed.
  // ---------------------------------------------------------------------------
  assign smp_ready = (state == S_IDLE);
  assign smp_acc   = smp_valid && smp_ready;
  assign ch_ok     = (32'(smp.channel) < 32'(CHANNELS));
  assign in_idx    = CH_W'(smp.channel);

  // Magnitude in unsigned Q1.23; the most negative sample keeps its full 2^23 magnitude.
  assign mag_full   = smp.sample[SAMPLE_BITS-1]
                      ? ({1'b0, ~smp.sample} + (SAMPLE_BITS+1)'(1))
                      : {1'b0, smp.sample};
  assign mag_scaled = {mag_full, 24'b0} >> SAMPLE_BITS;
  assign in_mag     = mag_scaled[LEVEL_W-1:0];

  // ---------------------------------------------------------------------------
  // Channel memory: one write port at the current channel, one registered read
  // port addressed straight from the incoming item.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_ch] <= mem_wdata;
    end
    rd_data <= mem[in_idx];
    rd_vld  <= vld[in_idx];
  end

  // a channel never written reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[cur_ch] <= 1'b1;
    end
  end

  assign word = rd_vld ? rd_data : '0;

  // ---------------------------------------------------------------------------
  // Modify: running maximum, saturating count, age growth and hold choice.
  // ---------------------------------------------------------------------------
  assign new_max   = (cur_mag > word.bmax) ? cur_mag : word.bmax;
  assign new_cnt   = (word.cnt < CNT_W'(MAX_BLOCK)) ? word.cnt + CNT_W'(1) : word.cnt;
  assign age_sum   = {1'b0, age} + (LEVEL_W+1)'(cnt);
  assign age_grown = age_sum[LEVEL_W] ? AGE_MAX : age_sum[LEVEL_W-1:0];
  assign take_peak = (peak > dec_rsp.level);
  assign closing   = (cur_mode == MODE_SAMPLE) && cur_end;
  assign res_load  = (state == S_EMIT) && (!res_valid || res_ready);

  // Decay requests: first the old hold, then the hold after the update.
  always_comb begin
    dec_req = '0;
    unique case (state)
      S_READ: begin
        dec_req.start = closing;
        dec_req.held  = clear_each_block ? '0 : word.held;
        dec_req.age   = clear_each_block ? '0 : word.age;
      end
      S_DECAY_OLD: begin
        dec_req.start = dec_rsp.done;
        dec_req.held  = take_peak ? peak : held;
        dec_req.age   = take_peak ? '0 : age_grown;
      end
      default: dec_req = '0;
    endcase
  end

  // Write back: a clear zeroes the word, an open block stores the new max and
  // count, a closed block restarts its max and count and keeps the new hold.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state)
      S_READ: begin
        mem_we = !closing;
        if (cur_mode == MODE_SAMPLE) begin
          mem_wdata = '{bmax: new_max, cnt: new_cnt, held: word.held, age: word.age};
        end
      end
      S_EMIT: begin
        mem_we    = res_load;
        mem_wdata = '{bmax: '0, cnt: '0, held: held, age: age};
      end
      default: mem_we = 1'b0;
    endcase
  end

  pkmeter_decay u_decay (
    .clk          (clk),
    .rst          (rst),
    .tick_seconds (tick_seconds),
    .decay_gain   (decay_gain),
    .hold_floor   (hold_floor),
    .req          (dec_req),
    .rsp          (dec_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (smp_acc) begin
            cur_mode   <= smp.mode;
            cur_end    <= smp.block_end;
            cur_ch     <= in_idx;
            cur_out_ch <= smp.channel;
            cur_mag    <= in_mag;
            // drop items for channels that do not exist
            if (ch_ok) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (closing) begin
            peak  <= new_max;
            cnt   <= new_cnt;
            held  <= dec_req.held;
            age   <= dec_req.age;
            state <= S_DECAY_OLD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DECAY_OLD: begin
          if (dec_rsp.done) begin
            held  <= dec_req.held;
            age   <= dec_req.age;
            state <= S_DECAY_NEW;
          end
        end
        S_DECAY_NEW: begin
          if (dec_rsp.done) begin
            level <= dec_rsp.level;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold here until the output register is free
          if (res_load) begin
            res   <= '{out_channel: cur_out_ch, block_peak: peak,
                       hold_raw: held, hold_level: level};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ready_unit_free: assert property (@(posedge clk) disable iff (rst)
    smp_ready |-> !dec_rsp.busy)
    else $error("item taken while decay unit still busy");

  a_start_not_lost: assert property (@(posedge clk) disable iff (rst)
    dec_req.start |-> !dec_rsp.busy)
    else $error("decay request issued to a busy unit");

  a_decay_on_close: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECAY_OLD) |-> closing)
    else $error("decay sequence entered without a closed block");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ($past(state) == S_DECAY_NEW || $past(state) == S_EMIT))
    else $error("result stage reached without the second decay");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for the peak meter with decaying hold: random and directed items,
// an in-bench predictor of per-channel peak, hold and decay, and randomised handshakes.
// Depends on pkmeter_pkg and block_peak_meter_with_decaying_hold_core.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pkmeter_pkg::*;

  localparam int NUM_CH     = 8;
  localparam int BLOCK_SAT  = 65536;
  localparam int SETTLE     = 32;     // wait after the drain for a trailing item to settle
  localparam int LONG_STALL = 400;    // receiver hold-off that backs the block up
  localparam int REPORT_CAP = 200;
  localparam int LONG_BLOCK = 20;

  // Tracks per-channel meter state and the results each closed block must produce.
  class meter_tracker;
    logic [31:0] tick_per_sample;
    logic [15:0] cubic_gain;
    logic [23:0] level_floor;
    logic        clear_on_block;

    logic [23:0] peak_so_far      [NUM_CH];
    int          samples_in_block [NUM_CH];
    logic [23:0] kept_peak        [NUM_CH];
    logic [23:0] kept_age         [NUM_CH];

    pkmeter_result_t due_results[$];
    int errors;

    function new();
      tick_per_sample = TICK_RESET;
      cubic_gain      = GAIN_RESET;
      level_floor     = FLOOR_RESET;
      clear_on_block  = 1'b0;
      errors          = 0;
      for (int c = 0; c < NUM_CH; c++) begin
        peak_so_far[c]      = '0;
        samples_in_block[c] = 0;
        kept_peak[c]        = '0;
        kept_age[c]         = '0;
      end
    endfunction

    function void report(string what);
      errors++;
      if (errors <= REPORT_CAP) $display("%0t ns  mismatch: %s", $realtime, what);
    endfunction

    function void set_reg(pkmeter_reg_t idx, logic [31:0] value);
      case (idx)
        REG_TICK_SECONDS:     tick_per_sample = value;
        REG_DECAY_GAIN:       cubic_gain      = value[15:0];
        REG_HOLD_FLOOR:       level_floor     = value[23:0];
        REG_CLEAR_EACH_BLOCK: clear_on_block  = value[0];
        default: ;
      endcase
    endfunction

    // Cubic decay of a held peak after a given age, floored.
    function logic [23:0] decayed_level(logic [23:0] held, logic [23:0] age);
      logic [63:0] t, t2, t3, term, lvl;
      t    = (64'(age) * 64'(tick_per_sample)) >> 16;
      term = '0;
      if (t > 64'(T_CLAMP)) t = 64'(T_CLAMP);
      if (cubic_gain != '0) begin
        t2   = (t * t) >> 16;
        t3   = (t2 * t) >> 16;
        term = (t3 * 64'(cubic_gain)) >> 16;
      end
      if (term >= 64'(Q16_ONE))
        lvl = '0;
      else
        lvl = (64'(held) * (64'(Q16_ONE) - term)) >> 16;
      if (lvl < 64'(level_floor)) lvl = 64'(level_floor);
      return lvl[23:0];
    endfunction

    function void note_item(pkmeter_item_t it);
      int unsigned     ch;
      logic [23:0]     raw, mag, peak, level_before;
      logic [31:0]     older;
      pkmeter_result_t r;
      ch = it.channel;
      if (ch >= NUM_CH) return;
      if (it.mode == MODE_CLEAR) begin
        peak_so_far[ch]      = '0;
        samples_in_block[ch] = 0;
        kept_peak[ch]        = '0;
        kept_age[ch]         = '0;
        return;
      end
      raw = it.sample;
      mag = raw[23] ? (~raw + 24'd1) : raw;
      if (mag > peak_so_far[ch]) peak_so_far[ch] = mag;
      if (samples_in_block[ch] < BLOCK_SAT) samples_in_block[ch]++;
      if (!it.block_end) return;

      if (clear_on_block) begin
        kept_peak[ch] = '0;
        kept_age[ch]  = '0;
      end
      peak         = peak_so_far[ch];
      level_before = decayed_level(kept_peak[ch], kept_age[ch]);
      if (peak > level_before) begin
        kept_peak[ch] = peak;
        kept_age[ch]  = '0;
      end else begin
        older = 32'(kept_age[ch]) + 32'(samples_in_block[ch]);
        kept_age[ch] = (older > 32'(AGE_MAX)) ? AGE_MAX : older[23:0];
      end
      r.out_channel = it.channel;
      r.block_peak  = peak;
      r.hold_raw    = kept_peak[ch];
      r.hold_level  = decayed_level(kept_peak[ch], kept_age[ch]);
      due_results.push_back(r);
      peak_so_far[ch]      = '0;
      samples_in_block[ch] = 0;
    endfunction

    function void check_result(pkmeter_result_t got);
      pkmeter_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing due: ch %0d peak %h raw %h level %h",
                         got.out_channel, got.block_peak, got.hold_raw, got.hold_level));
        return;
      end
      want = due_results.pop_front();
      if (got.out_channel !== want.out_channel)
        report($sformatf("out_channel %0d, want %0d", got.out_channel, want.out_channel));
      if (got.block_peak !== want.block_peak)
        report($sformatf("ch %0d block_peak %h, want %h",
                         want.out_channel, got.block_peak, want.block_peak));
      if (got.hold_raw !== want.hold_raw)
        report($sformatf("ch %0d hold_raw %h, want %h",
                         want.out_channel, got.hold_raw, want.hold_raw));
      if (got.hold_level !== want.hold_level)
        report($sformatf("ch %0d hold_level %h, want %h",
                         want.out_channel, got.hold_level, want.hold_level));
    endfunction

    function void flush_leftover();
      while (due_results.size() > 0) begin
        report($sformatf("result never came for ch %0d", due_results[0].out_channel));
        void'(due_results.pop_front());
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            smp_valid;
  logic            smp_ready;
  pkmeter_item_t   smp;
  logic            res_valid;
  logic            res_ready = 1'b0;
  pkmeter_result_t res;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  meter_tracker sb;

  // Idling bounds per side, changed between phases; a zero bound gives back-to-back items.
  int smp_max_gap = 16;
  int res_max_gap = 16;
  // Long receiver hold-offs asked by the main sequence and taken by the receiver.
  int hold_off_asks  = 0;
  int hold_off_taken = 0;
  int ready_wait     = 0;

  block_peak_meter_with_decaying_hold_core #(
    .CHANNELS (NUM_CH),
    .MAX_BLOCK(BLOCK_SAT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .smp_valid(smp_valid),
    .smp_ready(smp_ready),
    .smp      (smp),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: check each accepted result, then hold ready low for a freshly drawn
  // number of cycles. A pending hold-off request overrides the draw with a long stall.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        sb.check_result(res);
        ready_wait = $urandom_range(0, res_max_gap);
      end
      if (hold_off_taken != hold_off_asks) begin
        hold_off_taken = hold_off_asks;
        ready_wait     = LONG_STALL;
      end
      if (ready_wait > 0) begin
        res_ready <= 1'b0;
        ready_wait--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  function automatic pkmeter_item_t mk_item(logic mode, int ch, logic [23:0] raw, logic last);
    pkmeter_item_t it;
    it.mode      = mode;
    it.channel   = CH_FIELD_W'(ch);
    it.sample    = raw;
    it.block_end = last;
    return it;
  endfunction

  // Mostly samples spread over all channels, a few clears, amplitudes from full
  // scale down to a handful of LSBs so that holds both refresh and decay.
  function automatic pkmeter_item_t random_item();
    logic [23:0] raw;
    logic        mode;
    case ($urandom_range(0, 9))
      0:       raw = 24'h7FFFFF;
      1:       raw = 24'h800000;
      2:       raw = $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
      default: raw = 24'($signed(24'($urandom)) >>> $urandom_range(0, 20));
    endcase
    mode = ($urandom_range(0, 19) == 0) ? MODE_CLEAR : MODE_SAMPLE;
    return mk_item(mode, $urandom_range(0, NUM_CH - 1), raw, $urandom_range(0, 3) == 0);
  endfunction

  // Offer one item after a random gap and hold it until accepted. Valid is not
  // lowered on acceptance, so a gapless next item keeps it high without a glitch.
  task automatic send_item(pkmeter_item_t it);
    int gap;
    gap = $urandom_range(0, smp_max_gap);
    if (gap > 0) begin
      smp_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_valid <= 1'b1;
    smp       <= it;
    @(posedge clk);
    while (!smp_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item());
    smp_valid <= 1'b0;
  endtask

  task automatic write_reg(pkmeter_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic set_registers(logic [31:0] tick, logic [15:0] gain, logic [23:0] lvl,
                               logic clr);
    write_reg(REG_TICK_SECONDS, tick);
    write_reg(REG_DECAY_GAIN, 32'(gain));
    write_reg(REG_HOLD_FLOOR, 32'(lvl));
    write_reg(REG_CLEAR_EACH_BLOCK, 32'(clr));
    cfg_valid <= 1'b0;
  endtask

  // Drain every due result, then let any trailing clear or plain sample settle.
  task automatic wait_idle();
    while (sb.due_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int guard;
    sb = new();
    rst       <= 1'b1;
    smp_valid <= 1'b0;
    smp       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed, reset settings: full-scale extremes, most negative sample, zero,
    // multi-sample blocks, a hold that is not beaten, and clears with stray fields.
    send_item(mk_item(MODE_SAMPLE, 0, 24'h7FFFFF, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 1, 24'h800000, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 2, 24'h000000, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 2, 24'hFFFFFF, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 3, 24'd100, 1'b0));
    send_item(mk_item(MODE_SAMPLE, 3, -24'sd5000, 1'b0));
    send_item(mk_item(MODE_SAMPLE, 3, 24'd200, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 0, 24'd1, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 0, 24'd1, 1'b1));
    send_item(mk_item(MODE_CLEAR,  0, 24'h7FFFFF, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 0, 24'd1000, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 1, 24'd7, 1'b0));
    send_item(mk_item(MODE_CLEAR,  1, 24'h800000, 1'b0));
    send_item(mk_item(MODE_SAMPLE, 1, 24'd7, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 4, 24'h800000, 1'b0));
    send_item(mk_item(MODE_SAMPLE, 4, 24'h7FFFFF, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 7, 24'h555555, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 6, 24'hAAAAAA, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 5, 24'h000001, 1'b1));
    smp_valid <= 1'b0;
    wait_idle();

    // Extreme settings: fastest tick, strongest gain, full-scale floor, clear per block.
    set_registers(32'hFFFF_FFFF, 16'hFFFF, 24'h800000, 1'b1);
    send_item(mk_item(MODE_SAMPLE, 0, 24'h7FFFFF, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 1, 24'h800000, 1'b1));
    send_item(mk_item(MODE_SAMPLE, 1, 24'h000000, 1'b1));
    run_random(90);
    wait_idle();

    // All-zero settings, back-to-back items and a long receiver stall that backs the
    // block up until it refuses input.
    set_registers(32'h0, 16'h0, 24'h0, 1'b0);
    smp_max_gap = 0;
    hold_off_asks++;
    run_random(90);
    smp_max_gap = 16;
    wait_idle();

    // Mid-range tick and random gain and floor, where the decay bites after a few
    // hundred samples.
    set_registers($urandom_range(32'h0010_0000, 32'h1000_0000), 16'($urandom),
                  24'($urandom_range(0, 16'hFFFF)), 1'b0);
    run_random(90);
    wait_idle();

    // One-second tick with the weakest gain; receiver never idles.
    res_max_gap = 0;
    set_registers(32'hFFFF_FFFF, 16'h0001, 24'h0, 1'b0);
    run_random(90);
    wait_idle();
    res_max_gap = 16;

    // Back to reset values, then a longer back-to-back block on one channel.
    set_registers(TICK_RESET, GAIN_RESET, FLOOR_RESET, 1'b0);
    run_random(60);
    send_item(mk_item(MODE_SAMPLE, 5, 24'h400000, 1'b1));
    smp_max_gap = 0;
    for (int i = 0; i < LONG_BLOCK; i++)
      send_item(mk_item(MODE_SAMPLE, 5, 24'($signed(24'($urandom)) >>> 13),
                        i == LONG_BLOCK - 1));
    send_item(mk_item(MODE_SAMPLE, 5, 24'd10, 1'b1));
    smp_valid <= 1'b0;
    smp_max_gap = 16;

    // Drain with a bound, then watch a little longer for strays.
    guard = 0;
    while (sb.due_results.size() > 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    sb.flush_leftover();
    if (sb.errors == 0)
      $display("** block_peak_meter_with_decaying_hold_core: PASSED **");
    else
      $display("** block_peak_meter_with_decaying_hold_core: FAILED **");
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("** block_peak_meter_with_decaying_hold_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/pkmeter_pkg.sv
design/pkmeter_decay.sv
design/block_peak_meter_with_decaying_hold_core.sv
test/tb_top.sv
